>>> hdl/assert_macros.svh
// Assertion macros for the checker file.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the condition.
`define ASSERT_IMPLY(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed: same-cycle implication");

// Consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/psl_pkg.sv
// ----------------------------------------------------------------------------
// Per-source packet limiter package
// Shared widths, request and response types, table entry layout and
// configuration register codes.
// ----------------------------------------------------------------------------
package psl_pkg;

    // Field widths.
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int COUNT_W = 8;
    localparam int SLOT_W  = 4;

    // Default table depth.
    localparam int TABLE_ENTRIES_DEF = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [COUNT_W-1:0] DROP_LIMIT_RST = 8'd3;

    // Register word index, taken from paddr[2].
    typedef enum logic {
        REG_DROP_LIMIT = 1'b0,
        REG_UNUSED     = 1'b1
    } t_reg_idx;

    // One arriving packet.
    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [PORT_W-1:0] src_port;
    } t_req;

    // Verdict for one packet.
    typedef struct packed {
        logic               forward;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } t_rsp;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [PORT_W-1:0]  port;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

>>> hdl/psl_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register block holding the drop limit.
// ----------------------------------------------------------------------------
module psl_cfg_regs
    import psl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    o_drop_limit
);

    logic [COUNT_W-1:0] r_drop_limit;
    t_reg_idx           reg_idx;
    logic               wr_en;

    // Word index and write strobe.
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Drop limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_limit <= DROP_LIMIT_RST;
        end else if (wr_en && (reg_idx == REG_DROP_LIMIT)) begin
            r_drop_limit <= pwdata[COUNT_W-1:0];
        end
    end

    // Read mux.
    always_comb begin
        unique case (reg_idx)
            REG_DROP_LIMIT: prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, r_drop_limit};
            default:        prdata = '0;
        endcase
    end

    assign o_drop_limit = r_drop_limit;

endmodule

>>> hdl/per_source_packet_limiter.sv
// Operation: a request is accepted, then the table memory is scanned one entry per cycle.
// The scan stops at the first matching entry, or after the last entry on a miss; the
// verdict is then loaded into the response register, held back while the output stalls.
// Requests are taken one at a time: a new request stalls until the response is loaded.
// Reset (synchronous): valid bits, insertion pointer and control clear; drop limit returns to 3.
// ----------------------------------------------------------------------------
// Per-source packet limiter
// Looks up each packet's source in a table memory, counts packets per source,
// drops them above the limit and replaces entries in FIFO order on a miss.
// ----------------------------------------------------------------------------
module per_source_packet_limiter
    import psl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_stall,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_stall,
    output t_rsp                  o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // Index increment with wrap at the table depth.
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == LAST_IDX) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    t_state             r_state;
    t_req               r_key;
    logic [IDX_W-1:0]   r_scan_idx;
    logic [IDX_W-1:0]   r_data_idx;
    logic               r_data_vld;
    logic               r_hit;
    logic [IDX_W-1:0]   r_slot;
    logic [COUNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]   r_ptr;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    t_entry             r_mem [TABLE_ENTRIES];
    t_entry             r_rd_data;

    logic [COUNT_W-1:0] drop_limit;
    logic               req_accept;
    logic               rsp_free;
    logic               match;
    logic               n_forward;
    logic [COUNT_W-1:0] n_count;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic               wr_en;
    t_entry             wr_data;

    // Configuration registers.
    psl_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_drop_limit (drop_limit)
    );

    // Handshakes.
    assign o_req_stall = (r_state != ST_IDLE);
    assign req_accept  = i_req_valid && !o_req_stall;
    assign rsp_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Compare the entry read last cycle against the request key.
    assign match = r_data_vld && r_valid[r_data_idx]
                   && (r_rd_data.addr == r_key.src_addr)
                   && (r_rd_data.port == r_key.src_port);

    // Verdict and new count for the selected entry.
    always_comb begin
        if (!r_hit) begin
            n_forward = 1'b1;
            n_count   = COUNT_W'(1);
        end else if (r_cnt < drop_limit) begin
            n_forward = 1'b1;
            n_count   = r_cnt + 1'b1;
        end else begin
            n_forward = 1'b0;
            n_count   = r_cnt;
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, r_slot};
    assign wr_en    = (r_state == ST_UPDATE) && rsp_free;
    assign wr_data  = '{addr: r_key.src_addr, port: r_key.src_port, count: n_count};

    // Table memory: one read port, one write port, registered read data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_scan_idx];
        if (wr_en) begin
            r_mem[r_slot] <= wr_data;
        end
    end

    // Request key and scan payload registers.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_key <= i_req;
        end
        if (r_state == ST_SCAN) begin
            r_data_idx <= r_scan_idx;
            if (match) begin
                r_slot <= r_data_idx;
                r_cnt  <= r_rd_data.count;
            end else begin
                r_slot <= r_ptr;
                r_cnt  <= '0;
            end
        end
    end

    // Response valid: set when a response is loaded, cleared once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (wr_en) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // Sequencer with response register, valid bits and insertion pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_idx  <= '0;
            r_data_vld  <= 1'b0;
            r_hit       <= 1'b0;
            r_ptr       <= '0;
            r_valid     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_scan_idx <= '0;
                    r_data_vld <= 1'b0;
                    if (req_accept) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_scan_idx <= idx_next(r_scan_idx);
                    r_data_vld <= 1'b1;
                    if (match) begin
                        r_hit   <= 1'b1;
                        r_state <= ST_UPDATE;
                    end else if (r_data_vld && (r_data_idx == LAST_IDX)) begin
                        r_hit   <= 1'b0;
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (rsp_free) begin
                        r_rsp.forward <= n_forward;
                        r_rsp.hit     <= r_hit;
                        r_rsp.slot    <= slot_ext[SLOT_W-1:0];
                        r_rsp.count   <= n_count;
                        if (!r_hit) begin
                            r_valid[r_slot] <= 1'b1;
                            r_ptr           <= idx_next(r_ptr);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/psl_checker.sv
// ----------------------------------------------------------------------------
// Per-source packet limiter checker
// Port-level assertions on request flow and response consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psl_checker
    import psl_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);

    // A held response keeps its valid and its payload.
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp))

    // One request at a time: the block stalls right after taking a request.
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall)

    // A newly inserted source is always forwarded with a count of one.
    `ASSERT_IMPLY(a_miss_inserts, i_clk, i_rst_n, o_rsp_valid && !o_rsp.hit, o_rsp.forward && (o_rsp.count == 8'd1))

    // A forwarded hit has been counted at least twice.
    `ASSERT_IMPLY(a_hit_counts, i_clk, i_rst_n, o_rsp_valid && o_rsp.hit && o_rsp.forward, (o_rsp.count != 8'd0) && (o_rsp.count != 8'd1))

endmodule

bind per_source_packet_limiter psl_checker u_psl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);
